FILE: rtl/core/cartesian_to_spherical_macros.svh
// assertion macros shared by the cartesian to spherical rtl
`ifndef CARTESIAN_TO_SPHERICAL_MACROS_SVH
`define CARTESIAN_TO_SPHERICAL_MACROS_SVH
// same-cycle implication, checked outside reset
`define C2S_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, checked outside reset
`define C2S_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/core/c2s_pkg.sv
// shared constants, types and helper functions for the cartesian to spherical block
package c2s_pkg;

  // number of cordic micro-rotations
  localparam int CORDIC_STAGES = 32;
  // cordic datapath width and angle accumulator width
  localparam int CW = 60;
  localparam int AW = 64;
  // square root: one result bit per stage plus a rounding stage
  localparam int SQ_STEPS = 32;
  localparam int SQ_LAT   = SQ_STEPS + 1;
  // cordic: pre-rotation, micro-rotations, rounding
  localparam int CD_LAT   = CORDIC_STAGES + 2;
  // register stages ahead of the square root units
  localparam int FRONT_STAGES = 7;
  localparam int PIPE_DEPTH   = FRONT_STAGES + SQ_LAT + CD_LAT;

  localparam logic signed [AW-1:0] PI_Q60         = 64'sh3243F6A8885A308D;
  localparam logic signed [AW-1:0] QUARTER_PI_Q60 = 64'sh0C90FDAA22168C23;
  localparam logic signed [AW-1:0] RND_HALF       = 64'sh0000000040000000;
  localparam logic signed [32:0]   PI_Q29         = 33'sd1686629713;
  localparam logic signed [32:0]   NEG_PI_Q29     = -33'sd1686629713;

  // delayed alongside the square root units
  typedef struct packed {
    logic signed [32:0] zn;
    logic signed [32:0] axn;
    logic signed [32:0] ayn;
    logic               nz_p;
    logic               nz_a;
  } c2s_side_sq_t;

  // delayed alongside the cordic units
  typedef struct packed {
    logic [32:0] radius;
    logic        nz_p;
    logic        nz_a;
  } c2s_side_cd_t;

  // floor(2^e / d) by restoring long division, elaboration only
  function automatic logic [63:0] pow2_div(input int e, input logic [63:0] d);
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] q;
    num = 64'd1 << e;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= d) begin
        rem  = rem - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // arctan(2^-i) in q60 from the truncated power series
  function automatic logic signed [AW-1:0] atan_q60(input int i);
    logic signed [AW-1:0] acc;
    int e;
    acc = '0;
    if (i == 0) begin
      acc = QUARTER_PI_Q60;
    end else begin
      for (int k = 0; k < 31; k++) begin
        if (i * (2 * k + 1) <= 60) begin
          e = 60 - i * (2 * k + 1);
          if (k % 2 == 1) acc = acc - signed'(pow2_div(e, 64'(2 * k + 1)));
          else            acc = acc + signed'(pow2_div(e, 64'(2 * k + 1)));
        end
      end
    end
    return acc;
  endfunction

  // left shift that brings a magnitude into [2^30, 2^31]
  function automatic logic [4:0] norm_shift(input logic [31:0] m);
    logic [4:0] s;
    s = '0;
    for (int i = 0; i < 30; i++) begin
      if (m[i]) s = 5'(30 - i);
    end
    if (m[31:30] != 2'b00) s = '0;
    return s;
  endfunction

  // magnitude of a signed 32-bit value
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

endpackage

FILE: rtl/core/c2s_isqrt.sv
// pipelined integer square root, rounded to nearest, one root bit per stage
module c2s_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] n_i,
  output logic [32:0] root_o
);
  import c2s_pkg::*;

  logic [34:0] rem_r  [SQ_STEPS];
  logic [31:0] root_r [SQ_STEPS];
  logic [63:0] rest_r [SQ_STEPS];

  // one digit step per stage
  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_step
    logic [34:0] prem;
    logic [31:0] proot;
    logic [63:0] prest;
    logic [34:0] cur;
    logic [34:0] trial;

    if (j == 0) begin : g_first
      assign prem  = '0;
      assign proot = '0;
      assign prest = n_i;
    end else begin : g_next
      assign prem  = rem_r[j-1];
      assign proot = root_r[j-1];
      assign prest = rest_r[j-1];
    end

    assign cur   = {prem[32:0], prest[63:62]};
    assign trial = {1'b0, proot, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        rest_r[j] <= {prest[61:0], 2'b00};
        if (cur >= trial) begin
          rem_r[j]  <= cur - trial;
          root_r[j] <= {proot[30:0], 1'b1};
        end else begin
          rem_r[j]  <= cur;
          root_r[j] <= {proot[30:0], 1'b0};
        end
      end
    end
  end

  // round up when the remainder exceeds the floor root
  always_ff @(posedge clk) begin
    if (en) begin
      root_o <= {1'b0, root_r[SQ_STEPS-1]}
              + 33'(rem_r[SQ_STEPS-1] > {3'b000, root_r[SQ_STEPS-1]});
    end
  end

endmodule

FILE: rtl/core/c2s_cordic.sv
// pipelined vectoring cordic: atan2(b, a) rounded to q29 radians
module c2s_cordic (
  input  logic               clk,
  input  logic               en,
  input  logic signed [33:0] a_i,
  input  logic signed [33:0] b_i,
  output logic signed [32:0] angle_o
);
  import c2s_pkg::*;

  logic signed [CW-1:0] a_r [CORDIC_STAGES+1];
  logic signed [CW-1:0] b_r [CORDIC_STAGES+1];
  logic signed [AW-1:0] g_r [CORDIC_STAGES+1];
  logic signed [CW-1:0] a_ext;
  logic signed [CW-1:0] b_ext;
  logic signed [AW-1:0] rnd;

  // scale operands by 2^24
  assign a_ext = {{(CW-34){a_i[33]}}, a_i} <<< 24;
  assign b_ext = {{(CW-34){b_i[33]}}, b_i} <<< 24;

  // turn the vector by pi into the right half plane
  always_ff @(posedge clk) begin
    if (en) begin
      if (a_ext[CW-1]) begin
        a_r[0] <= -a_ext;
        b_r[0] <= -b_ext;
        g_r[0] <= b_ext[CW-1] ? -PI_Q60 : PI_Q60;
      end else begin
        a_r[0] <= a_ext;
        b_r[0] <= b_ext;
        g_r[0] <= '0;
      end
    end
  end

  // micro-rotations toward the a axis
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    localparam logic signed [AW-1:0] ATAN_I = atan_q60(i);
    always_ff @(posedge clk) begin
      if (en) begin
        if (!b_r[i][CW-1]) begin
          a_r[i+1] <= a_r[i] + (b_r[i] >>> i);
          b_r[i+1] <= b_r[i] - (a_r[i] >>> i);
          g_r[i+1] <= g_r[i] + ATAN_I;
        end else begin
          a_r[i+1] <= a_r[i] - (b_r[i] >>> i);
          b_r[i+1] <= b_r[i] + (a_r[i] >>> i);
          g_r[i+1] <= g_r[i] - ATAN_I;
        end
      end
    end
  end

  // q60 to q29, round half up
  assign rnd = g_r[CORDIC_STAGES] + RND_HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      angle_o <= rnd[63:31];
    end
  end

endmodule

FILE: rtl/core/cartesian_to_spherical.sv
// top level: cartesian vector to radius, polar angle and azimuth
//
// Input beat: in_coord_x/y/z, signed q15.16, taken when in_valid and in_ready.
// Output beat: out_radius (unsigned q17.16), out_polar_angle (q2.29, 0..pi)
// and out_azimuth (signed q2.29, -pi..pi), taken when out_valid and out_ready.
// From the input beat to the output register there are 75 register stages:
// 7 front stages (magnitudes, squares, normalizing shifts), 33 for the
// square root units, 34 for the two cordic units, 1 output register.
// Throughput is one beat per cycle unless stalled; all stages share one enable.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready drops; in_ready is high whenever the output register is
// empty or being taken. Reset clears all valid bits; no data is flushed.
// A zero vector gives a zero polar angle, x = y = 0 gives a zero azimuth.
`include "cartesian_to_spherical_macros.svh"
module cartesian_to_spherical (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_coord_x,
  input  logic [31:0] in_coord_y,
  input  logic [31:0] in_coord_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [32:0] out_radius,
  output logic [30:0] out_polar_angle,
  output logic [31:0] out_azimuth
);
  import c2s_pkg::*;

  logic en;
  logic vld_r [PIPE_DEPTH];
  logic out_valid_r;

  // stage 1: input registers
  logic signed [31:0] s1_x_r, s1_y_r, s1_z_r;
  // stage 2: magnitudes and maxima
  logic signed [31:0] s2_x_r, s2_y_r, s2_z_r;
  logic [31:0] s2_ax_r, s2_ay_r, s2_az_r, s2_mxy_r, s2_mall_r;
  // stage 3: squares and shift counts
  logic signed [31:0] s3_x_r, s3_y_r, s3_z_r;
  logic [63:0] s3_sqx_r, s3_sqy_r, s3_sqz_r;
  logic [4:0]  s3_sp_r, s3_sa_r;
  logic        s3_nzp_r, s3_nza_r;
  // stage 4: radius sum and normalized components
  logic [63:0] s4_rsum_r;
  logic signed [32:0] s4_pxn_r, s4_pyn_r, s4_pzn_r, s4_axn_r, s4_ayn_r;
  logic        s4_nzp_r, s4_nza_r;
  // stage 5: magnitudes of normalized x, y
  logic [63:0] s5_rsum_r;
  logic [31:0] s5_mpx_r, s5_mpy_r;
  logic signed [32:0] s5_zn_r, s5_axn_r, s5_ayn_r;
  logic        s5_nzp_r, s5_nza_r;
  // stage 6: squares of normalized x, y
  logic [63:0] s6_rsum_r;
  logic [63:0] s6_sqpx_r, s6_sqpy_r;
  logic signed [32:0] s6_zn_r, s6_axn_r, s6_ayn_r;
  logic        s6_nzp_r, s6_nza_r;
  // stage 7: square root operands
  logic [63:0] s7_rsum_r, s7_psum_r;
  logic signed [32:0] s7_zn_r, s7_axn_r, s7_ayn_r;
  logic        s7_nzp_r, s7_nza_r;

  c2s_side_sq_t side_sq_r [SQ_LAT];
  c2s_side_sq_t side_sq_in;
  c2s_side_cd_t side_cd_r [CD_LAT];
  c2s_side_cd_t side_cd_in;

  logic [32:0] radius_root;
  logic [32:0] rxy_root;
  logic signed [32:0] polar_ang, azim_ang;
  logic [30:0] polar_nxt;
  logic [31:0] azim_nxt;
  logic [32:0] out_radius_r;
  logic [30:0] out_polar_r;
  logic [31:0] out_azim_r;

  // whole pipeline moves when the output register can take a beat
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PIPE_DEPTH; k++) vld_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < PIPE_DEPTH; k++) vld_r[k] <= vld_r[k-1];
      out_valid_r <= vld_r[PIPE_DEPTH-1];
    end
  end

  // front stages
  always_ff @(posedge clk) begin
    if (en) begin
      s1_x_r <= in_coord_x;
      s1_y_r <= in_coord_y;
      s1_z_r <= in_coord_z;

      s2_x_r    <= s1_x_r;
      s2_y_r    <= s1_y_r;
      s2_z_r    <= s1_z_r;
      s2_ax_r   <= mag32(s1_x_r);
      s2_ay_r   <= mag32(s1_y_r);
      s2_az_r   <= mag32(s1_z_r);
      s2_mxy_r  <= (mag32(s1_x_r) > mag32(s1_y_r)) ? mag32(s1_x_r) : mag32(s1_y_r);
      s2_mall_r <= (mag32(s1_x_r) > mag32(s1_y_r))
                 ? ((mag32(s1_z_r) > mag32(s1_x_r)) ? mag32(s1_z_r) : mag32(s1_x_r))
                 : ((mag32(s1_z_r) > mag32(s1_y_r)) ? mag32(s1_z_r) : mag32(s1_y_r));

      s3_x_r   <= s2_x_r;
      s3_y_r   <= s2_y_r;
      s3_z_r   <= s2_z_r;
      s3_sqx_r <= 64'(s2_ax_r) * 64'(s2_ax_r);
      s3_sqy_r <= 64'(s2_ay_r) * 64'(s2_ay_r);
      s3_sqz_r <= 64'(s2_az_r) * 64'(s2_az_r);
      s3_sp_r  <= norm_shift(s2_mall_r);
      s3_sa_r  <= norm_shift(s2_mxy_r);
      s3_nzp_r <= (s2_mall_r != '0);
      s3_nza_r <= (s2_mxy_r != '0);

      s4_rsum_r <= s3_sqx_r + s3_sqy_r + s3_sqz_r;
      s4_pxn_r  <= {s3_x_r[31], s3_x_r} <<< s3_sp_r;
      s4_pyn_r  <= {s3_y_r[31], s3_y_r} <<< s3_sp_r;
      s4_pzn_r  <= {s3_z_r[31], s3_z_r} <<< s3_sp_r;
      s4_axn_r  <= {s3_x_r[31], s3_x_r} <<< s3_sa_r;
      s4_ayn_r  <= {s3_y_r[31], s3_y_r} <<< s3_sa_r;
      s4_nzp_r  <= s3_nzp_r;
      s4_nza_r  <= s3_nza_r;

      s5_rsum_r <= s4_rsum_r;
      s5_mpx_r  <= s4_pxn_r[32] ? 32'(-s4_pxn_r) : s4_pxn_r[31:0];
      s5_mpy_r  <= s4_pyn_r[32] ? 32'(-s4_pyn_r) : s4_pyn_r[31:0];
      s5_zn_r   <= s4_pzn_r;
      s5_axn_r  <= s4_axn_r;
      s5_ayn_r  <= s4_ayn_r;
      s5_nzp_r  <= s4_nzp_r;
      s5_nza_r  <= s4_nza_r;

      s6_rsum_r <= s5_rsum_r;
      s6_sqpx_r <= 64'(s5_mpx_r) * 64'(s5_mpx_r);
      s6_sqpy_r <= 64'(s5_mpy_r) * 64'(s5_mpy_r);
      s6_zn_r   <= s5_zn_r;
      s6_axn_r  <= s5_axn_r;
      s6_ayn_r  <= s5_ayn_r;
      s6_nzp_r  <= s5_nzp_r;
      s6_nza_r  <= s5_nza_r;

      s7_rsum_r <= s6_rsum_r;
      s7_psum_r <= s6_sqpx_r + s6_sqpy_r;
      s7_zn_r   <= s6_zn_r;
      s7_axn_r  <= s6_axn_r;
      s7_ayn_r  <= s6_ayn_r;
      s7_nzp_r  <= s6_nzp_r;
      s7_nza_r  <= s6_nza_r;
    end
  end

  // radius and sqrt(x^2 + y^2) of the normalized vector
  c2s_isqrt u_isqrt_radius (
    .clk    (clk),
    .en     (en),
    .n_i    (s7_rsum_r),
    .root_o (radius_root)
  );

  c2s_isqrt u_isqrt_rxy (
    .clk    (clk),
    .en     (en),
    .n_i    (s7_psum_r),
    .root_o (rxy_root)
  );

  // side data across the square root units
  always_comb begin
    side_sq_in        = '0;
    side_sq_in.zn     = s7_zn_r;
    side_sq_in.axn    = s7_axn_r;
    side_sq_in.ayn    = s7_ayn_r;
    side_sq_in.nz_p   = s7_nzp_r;
    side_sq_in.nz_a   = s7_nza_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_sq_r[0] <= side_sq_in;
      for (int k = 1; k < SQ_LAT; k++) side_sq_r[k] <= side_sq_r[k-1];
    end
  end

  // polar angle atan2(rxy, z) and azimuth atan2(y, x)
  c2s_cordic u_cordic_polar (
    .clk     (clk),
    .en      (en),
    .a_i     ({side_sq_r[SQ_LAT-1].zn[32], side_sq_r[SQ_LAT-1].zn}),
    .b_i     ({1'b0, rxy_root}),
    .angle_o (polar_ang)
  );

  c2s_cordic u_cordic_azim (
    .clk     (clk),
    .en      (en),
    .a_i     ({side_sq_r[SQ_LAT-1].axn[32], side_sq_r[SQ_LAT-1].axn}),
    .b_i     ({side_sq_r[SQ_LAT-1].ayn[32], side_sq_r[SQ_LAT-1].ayn}),
    .angle_o (azim_ang)
  );

  // side data across the cordic units
  always_comb begin
    side_cd_in.radius = radius_root;
    side_cd_in.nz_p   = side_sq_r[SQ_LAT-1].nz_p;
    side_cd_in.nz_a   = side_sq_r[SQ_LAT-1].nz_a;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_cd_r[0] <= side_cd_in;
      for (int k = 1; k < CD_LAT; k++) side_cd_r[k] <= side_cd_r[k-1];
    end
  end

  // special cases and clamping
  always_comb begin
    if (!side_cd_r[CD_LAT-1].nz_p || polar_ang < 0) begin
      polar_nxt = '0;
    end else if (polar_ang > PI_Q29) begin
      polar_nxt = PI_Q29[30:0];
    end else begin
      polar_nxt = polar_ang[30:0];
    end

    if (!side_cd_r[CD_LAT-1].nz_a) begin
      azim_nxt = '0;
    end else if (azim_ang < NEG_PI_Q29) begin
      azim_nxt = NEG_PI_Q29[31:0];
    end else if (azim_ang > PI_Q29) begin
      azim_nxt = PI_Q29[31:0];
    end else begin
      azim_nxt = azim_ang[31:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_radius_r <= side_cd_r[CD_LAT-1].radius;
      out_polar_r  <= polar_nxt;
      out_azim_r   <= azim_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_radius      = out_radius_r;
  assign out_polar_angle = out_polar_r;
  assign out_azimuth     = out_azim_r;

  // checks
  `C2S_ASSERT_IMP(a_polar_range, out_valid_r, {2'b00, out_polar_r} <= PI_Q29, "polar out of range")
  `C2S_ASSERT_IMP(a_azim_range, out_valid_r, ($signed(out_azim_r) <= $signed(PI_Q29[31:0])) && ($signed(out_azim_r) >= $signed(NEG_PI_Q29[31:0])), "azimuth out of range")
  `C2S_ASSERT_IMP(a_zero_radius, out_valid_r && (out_radius_r == '0), out_polar_r == '0, "zero radius with nonzero polar angle")
  `C2S_ASSERT_NXT(a_stall_hold, !en, $stable(vld_r[PIPE_DEPTH-1]) && $stable(vld_r[0]), "pipeline moved during stall")

endmodule
